FILE: rtl/ipv4_route_table_lookup_defines.svh
// Assertion macros for the route table lookup block.
`ifndef IPV4_ROUTE_TABLE_LOOKUP_DEFINES_SVH
`define IPV4_ROUTE_TABLE_LOOKUP_DEFINES_SVH

`ifndef SYNTH

// Antecedent implies consequent in the same cycle.
`define RTLU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("route table check failed");

// Antecedent implies consequent in the next cycle.
`define RTLU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("route table check failed");

`else

`define RTLU_ASSERT_SAME(label, clk, rst, ante, cons)
`define RTLU_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/rtlu_pkg.sv
// Shared types and constants for the route table lookup block.
package rtlu_pkg;

   localparam int ENTRIES_DEFAULT = 16;

   typedef enum logic {
      FUNC_ADD    = 1'b0,
      FUNC_LOOKUP = 1'b1
   } func_type;

   // One stored route.
   typedef struct packed {
      logic        used;
      logic [31:0] net;
      logic [31:0] mask;
      logic [31:0] gateway;
      logic [15:0] metric;
      logic [1:0]  cls;
      logic [3:0]  device;
   } entry_type;

   // What a cell hands to its right neighbour for an insert.
   typedef struct packed {
      logic      ge;
      entry_type entry;
   } link_type;

   // Word travelling down the chain, one cell a cycle while the chain advances.
   typedef struct packed {
      logic        is_lookup;
      logic [31:0] addr;
      logic        hit;
      logic [31:0] gateway;
      logic [15:0] metric;
      logic [1:0]  cls;
      logic [3:0]  device;
      logic        full;
   } tok_type;

endpackage

FILE: rtl/rtlu_if.sv
// Request and response channel interfaces of the route table lookup block.
interface rtlu_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [31:0] address;
   logic [31:0] mask;
   logic [31:0] gateway;
   logic [15:0] route_metric;
   logic [1:0]  route_class;
   logic [3:0]  device;

   modport source (output valid, func, address, mask, gateway, route_metric,
                   route_class, device, input ready);
   modport sink   (input valid, func, address, mask, gateway, route_metric,
                   route_class, device, output ready);
endinterface

interface rtlu_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] next_hop;
   logic [3:0]  out_device;
   logic [1:0]  out_class;
   logic [15:0] out_metric;
   logic        table_full;

   modport source (output valid, hit, next_hop, out_device, out_class, out_metric,
                   table_full, input ready);
   modport sink   (input valid, hit, next_hop, out_device, out_class, out_metric,
                   table_full, output ready);
endinterface

FILE: rtl/rtlu_cell.sv
// One cell of the route chain: holds one route and one stage of the lookup pipeline.
module rtlu_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               ins_en,
   input  rtlu_pkg::entry_type new_entry,
   input  rtlu_pkg::link_type left_link,
   output rtlu_pkg::link_type own_link,
   input  logic               tok_valid_in,
   input  rtlu_pkg::tok_type  tok_in,
   output logic               tok_valid_out,
   output rtlu_pkg::tok_type  tok_out
);

   logic                used_ff, used_in;
   rtlu_pkg::entry_type data_ff, data_in;
   logic                tok_valid_ff, tok_valid_in_nxt;
   rtlu_pkg::tok_type   tok_ff, tok_in_nxt;
   logic                ge;
   logic                match;

   // Unused cells take any new route, so the boundary falls at the fill level.
   assign ge = !used_ff || (new_entry.mask >= data_ff.mask);

   always_comb begin
      own_link.ge         = ge;
      own_link.entry      = data_ff;
      own_link.entry.used = used_ff;
   end

   always_comb begin
      used_in = used_ff;
      data_in = data_ff;
      if (ins_en && ge) begin
         if (left_link.ge) begin
            // shift right by one
            used_in = left_link.entry.used;
            data_in = left_link.entry;
         end else begin
            used_in = 1'b1;
            data_in = new_entry;
         end
      end
   end

   assign match = used_ff &&
                  ((data_ff.mask & tok_in.addr) == (data_ff.mask & data_ff.net));

   always_comb begin
      tok_valid_in_nxt = tok_valid_ff;
      tok_in_nxt       = tok_ff;
      if (advance) begin
         tok_valid_in_nxt = tok_valid_in;
         tok_in_nxt       = tok_in;
         if (tok_in.is_lookup && !tok_in.hit && match) begin
            tok_in_nxt.hit     = 1'b1;
            tok_in_nxt.gateway = data_ff.gateway;
            tok_in_nxt.metric  = data_ff.metric;
            tok_in_nxt.cls     = data_ff.cls;
            tok_in_nxt.device  = data_ff.device;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         tok_valid_ff <= tok_valid_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      tok_ff  <= tok_in_nxt;
   end

   assign tok_valid_out = tok_valid_ff;
   assign tok_out       = tok_ff;

endmodule

FILE: rtl/ipv4_route_table_lookup.sv
// Top level of the IPv4 route table with longest prefix match.
// The table is a chain of ENTRIES cells, each holding one route, kept in
// descending order of netmask. An add is applied to the whole chain in the
// cycle it is accepted (cells at and after the insert point shift one place
// right) and is refused with table_full when the last cell is in use. Every
// word, lookup or add, then walks the chain one cell per cycle while the
// chain advances, and its result is delivered from the last cell. Lookups
// stream at one per cycle while responses are taken; an add is held off
// until every lookup already in the chain has delivered its result.
// No clearing pass is needed after reset. Response stalls freeze the chain.
`include "ipv4_route_table_lookup_defines.svh"

module ipv4_route_table_lookup #(
   parameter int ENTRIES = rtlu_pkg::ENTRIES_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   rtlu_req_if.sink      req_ch,
   rtlu_rsp_if.source    rsp_ch
);

   localparam int CW = $clog2(ENTRIES + 1);

   rtlu_pkg::link_type  links    [ENTRIES];
   logic                tok_valid[ENTRIES];
   rtlu_pkg::tok_type   toks     [ENTRIES];
   logic [ENTRIES-1:0]  used_vec;

   rtlu_pkg::entry_type new_entry;
   rtlu_pkg::link_type  head_link;
   rtlu_pkg::tok_type   req_tok;
   logic                advance;
   logic                is_add;
   logic                full;
   logic                req_acc;
   logic                rsp_acc;
   logic                ins_en;
   logic [CW-1:0]       lkp_cnt_ff, lkp_cnt_in;

   assign advance = !tok_valid[ENTRIES-1] || rsp_ch.ready;
   assign is_add  = (req_ch.func == rtlu_pkg::FUNC_ADD);
   assign full    = used_vec[ENTRIES-1];

   // hold adds back while lookups are still walking the chain
   assign req_ch.ready = advance && !(is_add && (lkp_cnt_ff != '0));
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_acc      = rsp_ch.valid && rsp_ch.ready;
   assign ins_en       = req_acc && is_add && !full;

   always_comb begin
      new_entry.used    = 1'b1;
      new_entry.net     = req_ch.address;
      new_entry.mask    = req_ch.mask;
      new_entry.gateway = req_ch.gateway;
      new_entry.metric  = req_ch.route_metric;
      new_entry.cls     = req_ch.route_class;
      new_entry.device  = req_ch.device;
      head_link.ge      = 1'b0;
      head_link.entry   = new_entry;

      req_tok           = '0;
      req_tok.is_lookup = !is_add;
      req_tok.addr      = req_ch.address;
      req_tok.full      = is_add && full;
   end

   genvar k;
   generate
      for (k = 0; k < ENTRIES; k++) begin : g_cell
         rtlu_cell u_cell (
            .clock         (clock),
            .reset         (reset),
            .advance       (advance),
            .ins_en        (ins_en),
            .new_entry     (new_entry),
            .left_link     ((k == 0) ? head_link : links[(k == 0) ? 0 : k - 1]),
            .own_link      (links[k]),
            .tok_valid_in  ((k == 0) ? req_acc : tok_valid[(k == 0) ? 0 : k - 1]),
            .tok_in        ((k == 0) ? req_tok : toks[(k == 0) ? 0 : k - 1]),
            .tok_valid_out (tok_valid[k]),
            .tok_out       (toks[k])
         );
         assign used_vec[k] = links[k].entry.used;
      end
   endgenerate

   always_comb begin
      lkp_cnt_in = lkp_cnt_ff;
      case ({req_acc && !is_add, rsp_acc && toks[ENTRIES-1].is_lookup})
         2'b10:   lkp_cnt_in = lkp_cnt_ff + CW'(1);
         2'b01:   lkp_cnt_in = lkp_cnt_ff - CW'(1);
         default: lkp_cnt_in = lkp_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lkp_cnt_ff <= '0;
      end else begin
         lkp_cnt_ff <= lkp_cnt_in;
      end
   end

   assign rsp_ch.valid      = tok_valid[ENTRIES-1];
   assign rsp_ch.hit        = toks[ENTRIES-1].hit;
   assign rsp_ch.next_hop   = toks[ENTRIES-1].gateway;
   assign rsp_ch.out_device = toks[ENTRIES-1].device;
   assign rsp_ch.out_class  = toks[ENTRIES-1].cls;
   assign rsp_ch.out_metric = toks[ENTRIES-1].metric;
   assign rsp_ch.table_full = toks[ENTRIES-1].full;

   `RTLU_ASSERT_SAME(a_add_chain_clear, clock, reset, req_acc && is_add, lkp_cnt_ff == '0)
   `RTLU_ASSERT_SAME(a_fill_contiguous, clock, reset, 1'b1, ((used_vec >> 1) & ~used_vec) == '0)
   `RTLU_ASSERT_NEXT(a_full_add_keeps, clock, reset, req_acc && is_add && full, $stable(used_vec))
   `RTLU_ASSERT_SAME(a_lookup_count, clock, reset, 1'b1, lkp_cnt_ff <= CW'(ENTRIES))

endmodule
